// ===== src/gesu_pkg.sv =====
// Shared constants, types and fixed-point helpers for the Gaussian elimination solver.
package gesu_pkg;

	localparam int MAX_EQUATIONS = 16;
	localparam int COLS          = MAX_EQUATIONS + 1;
	localparam int DEPTH         = MAX_EQUATIONS * COLS;
	localparam int ADDR_W        = $clog2(DEPTH);
	localparam int IDX_W         = $clog2(MAX_EQUATIONS);
	localparam int COL_W         = $clog2(MAX_EQUATIONS + 1);
	localparam int EQ_W          = 5;
	localparam int DATA_W        = 32;
	localparam int QUOT_W        = DATA_W + 16;
	localparam int CNT_W         = $clog2(QUOT_W);
	localparam int PIVOT_LIMIT   = 7;

	localparam logic signed [DATA_W-1:0] SMAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] SMIN = 32'sh80000000;

	// Request and response of the shared divider.
	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] dividend;
		logic signed [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] quot;
	} div_rsp_t;

	// Active system size: zero counts as one, large values clip to the maximum.
	function automatic logic [COL_W-1:0] active_n(input logic [EQ_W-1:0] eq);
		logic [COL_W-1:0] n;
		if (eq == '0) begin
			n = COL_W'(1);
		end else if (int'(eq) > MAX_EQUATIONS) begin
			n = COL_W'(MAX_EQUATIONS);
		end else begin
			n = COL_W'(eq);
		end
		return n;
	endfunction

	// Store address of one matrix entry.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
			input logic [COL_W-1:0] c);
		return ADDR_W'(int'(r) * COLS + int'(c));
	endfunction

	// Scales a full product back to Q16.16, truncating toward zero, with saturation.
	function automatic logic signed [DATA_W-1:0] qmul_finish(input logic signed [63:0] p);
		logic signed [63:0] t;
		logic signed [DATA_W-1:0] r;
		t = p[63] ? ((p + 64'sd65535) >>> 16) : (p >>> 16);
		if (t > 64'sd2147483647) begin
			r = SMAX;
		end else if (t < -64'sd2147483648) begin
			r = SMIN;
		end else begin
			r = t[DATA_W-1:0];
		end
		return r;
	endfunction

	// Saturating subtraction.
	function automatic logic signed [DATA_W-1:0] qsub(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		logic signed [DATA_W:0] d;
		logic signed [DATA_W-1:0] r;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] != d[DATA_W-1]) begin
			r = d[DATA_W] ? SMIN : SMAX;
		end else begin
			r = d[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== src/gaussian_elimination_solver_unit.sv =====
// Top level of the Gaussian elimination solver: load, sequencer, multiplier and output.
// Usage:
// Write register equations (n) at byte address 0 over the APB port while the block is
// idle; a write discards any partly loaded system. Then send the n*(n+1) elements of the
// augmented matrix in row-major order, one item per start pulse while busy is low.
// After the last element busy rises and the sequencer runs forward elimination and back
// substitution on one shared divider and one shared multiply-subtract path, with the
// matrix held in a single-port-read RAM. Each divide is a read step, a start step,
// 48 quotient bits in the iterative divider and a done step; each multiply-subtract
// step reads its operands, multiplies, scales and subtracts in turn.
// The n roots then appear in consecutive cycles, each marked by valid for one cycle,
// with root_index, last_root on the final root and singular set on every root when a
// pivot magnitude fell below 7 units of 2^-16. The receiver cannot stall the results.
// Busy falls when the final root is registered, so it is low while that root is shown.
// Reset sets n to 1, clears the load position and the singular flag; the matrix store
// needs no clearing, as every entry read in a run is written in that run.
module gaussian_elimination_solver_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] element,
	output logic               valid,
	output logic signed [31:0] root,
	output logic [3:0]         root_index,
	output logic               last_root,
	output logic               singular,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import gesu_pkg::*;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_PIV_RD   = 5'd1;
	localparam logic [4:0] S_PIV_CAP  = 5'd2;
	localparam logic [4:0] S_NRM_RD   = 5'd3;
	localparam logic [4:0] S_NRM_DIV  = 5'd4;
	localparam logic [4:0] S_NRM_WAIT = 5'd5;
	localparam logic [4:0] S_F_RD     = 5'd6;
	localparam logic [4:0] S_F_CAP    = 5'd7;
	localparam logic [4:0] S_E_RDK    = 5'd8;
	localparam logic [4:0] S_E_RDI    = 5'd9;
	localparam logic [4:0] S_E_MUL    = 5'd10;
	localparam logic [4:0] S_E_SCL    = 5'd11;
	localparam logic [4:0] S_E_SUB    = 5'd12;
	localparam logic [4:0] S_B_RD     = 5'd13;
	localparam logic [4:0] S_B_CAP    = 5'd14;
	localparam logic [4:0] S_B_RDA    = 5'd15;
	localparam logic [4:0] S_B_CAPA   = 5'd16;
	localparam logic [4:0] S_B_MUL    = 5'd17;
	localparam logic [4:0] S_B_SCL    = 5'd18;
	localparam logic [4:0] S_B_SUB    = 5'd19;
	localparam logic [4:0] S_B_STO    = 5'd20;
	localparam logic [4:0] S_OUT      = 5'd21;

	localparam logic REG_EQUATIONS = 1'b0;

	logic [4:0]               state_q;
	logic [EQ_W-1:0]          eq_q;
	logic [IDX_W-1:0]         row_q;
	logic [COL_W-1:0]         col_q;
	logic [IDX_W-1:0]         k_q;
	logic [IDX_W-1:0]         i_q;
	logic [COL_W-1:0]         j_q;
	logic                     sing_q;
	logic signed [DATA_W-1:0] pivot_q;
	logic signed [DATA_W-1:0] a_q;
	logic signed [DATA_W-1:0] b_q;
	logic signed [DATA_W-1:0] c_q;
	logic signed [63:0]       p_s1;
	logic signed [DATA_W-1:0] m_q;
	logic signed [DATA_W-1:0] xs_q [MAX_EQUATIONS];

	logic [COL_W-1:0]         n_act;
	logic [IDX_W-1:0]         nm1;
	logic                     cfg_wr;
	logic                     accept;
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [DATA_W-1:0]        ram_wdata;
	logic [ADDR_W-1:0]        ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;
	logic signed [DATA_W-1:0] rd_s;
	logic signed [DATA_W-1:0] diff;
	logic signed [DATA_W-1:0] x_rd;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	assign n_act  = active_n(eq_q);
	assign nm1    = IDX_W'(n_act - 1'b1);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = start && !busy;
	assign busy   = state_q != S_IDLE;
	assign rd_s   = $signed(ram_rdata);
	assign diff   = qsub(c_q, m_q);
	assign x_rd   = xs_q[j_q[IDX_W-1:0]];

	// Configuration port: one register, whose low five bits read back as written.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EQUATIONS) ? {27'd0, eq_q} : 32'd0;

	// Matrix store.
	gesu_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shared divider.
	gesu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		div_req.start    = state_q == S_NRM_DIV;
		div_req.dividend = rd_s;
		div_req.divisor  = pivot_q;
	end

	// Store write port: loading, normalised pivot row and eliminated rows.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cell_addr(row_q, col_q);
		ram_wdata = element;
		case (state_q)
			S_IDLE: begin
				ram_we = accept;
			end
			S_NRM_WAIT: begin
				ram_we    = div_rsp.done;
				ram_waddr = cell_addr(k_q, j_q);
				ram_wdata = div_rsp.quot;
			end
			S_E_SUB: begin
				ram_we    = 1'b1;
				ram_waddr = cell_addr(i_q, j_q);
				ram_wdata = diff;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Store read address for each step.
	always_comb begin
		case (state_q)
			S_PIV_RD: ram_raddr = cell_addr(k_q, COL_W'(k_q));
			S_NRM_RD: ram_raddr = cell_addr(k_q, j_q);
			S_F_RD:   ram_raddr = cell_addr(i_q, COL_W'(k_q));
			S_E_RDK:  ram_raddr = cell_addr(k_q, j_q);
			S_E_RDI:  ram_raddr = cell_addr(i_q, j_q);
			S_B_RD:   ram_raddr = cell_addr(i_q, n_act);
			S_B_RDA:  ram_raddr = cell_addr(i_q, j_q);
			default:  ram_raddr = cell_addr(i_q, j_q);
		endcase
	end

	// Shared multiplier and its scaling stage.
	always_ff @(posedge clk) begin
		p_s1 <= 64'(a_q) * 64'(b_q);
		m_q  <= qmul_finish(p_s1);
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eq_q    <= EQ_W'(1);
			row_q   <= '0;
			col_q   <= '0;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			sing_q  <= 1'b0;
			valid   <= 1'b0;
		end else begin
			valid <= 1'b0;
			if (cfg_wr && (paddr[2] == REG_EQUATIONS)) begin
				eq_q   <= pwdata[EQ_W-1:0];
				row_q  <= '0;
				col_q  <= '0;
				sing_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (col_q == n_act) begin
							col_q <= '0;
							if (row_q == nm1) begin
								row_q   <= '0;
								k_q     <= '0;
								state_q <= S_PIV_RD;
							end else begin
								row_q <= row_q + 1'b1;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				S_PIV_RD: begin
					state_q <= S_PIV_CAP;
				end
				S_PIV_CAP: begin
					if ((rd_s < DATA_W'(PIVOT_LIMIT)) && (rd_s > -DATA_W'(PIVOT_LIMIT))) begin
						sing_q <= 1'b1;
					end
					j_q     <= COL_W'(k_q);
					state_q <= S_NRM_RD;
				end
				S_NRM_RD: begin
					state_q <= S_NRM_DIV;
				end
				S_NRM_DIV: begin
					state_q <= S_NRM_WAIT;
				end
				S_NRM_WAIT: begin
					if (div_rsp.done) begin
						if (j_q == n_act) begin
							if (k_q == nm1) begin
								i_q     <= nm1;
								state_q <= S_B_RD;
							end else begin
								i_q     <= k_q + 1'b1;
								state_q <= S_F_RD;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_NRM_RD;
						end
					end
				end
				S_F_RD: begin
					state_q <= S_F_CAP;
				end
				S_F_CAP: begin
					j_q     <= COL_W'(k_q);
					state_q <= S_E_RDK;
				end
				S_E_RDK: begin
					state_q <= S_E_RDI;
				end
				S_E_RDI: begin
					state_q <= S_E_MUL;
				end
				S_E_MUL: begin
					state_q <= S_E_SCL;
				end
				S_E_SCL: begin
					state_q <= S_E_SUB;
				end
				S_E_SUB: begin
					if (j_q == n_act) begin
						if (i_q == nm1) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_PIV_RD;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_F_RD;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_E_RDK;
					end
				end
				S_B_RD: begin
					state_q <= S_B_CAP;
				end
				S_B_CAP: begin
					j_q     <= COL_W'(i_q) + 1'b1;
					state_q <= (i_q == nm1) ? S_B_STO : S_B_RDA;
				end
				S_B_RDA: begin
					state_q <= S_B_CAPA;
				end
				S_B_CAPA: begin
					state_q <= S_B_MUL;
				end
				S_B_MUL: begin
					state_q <= S_B_SCL;
				end
				S_B_SCL: begin
					state_q <= S_B_SUB;
				end
				S_B_SUB: begin
					if (j_q == COL_W'(nm1)) begin
						state_q <= S_B_STO;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_B_RDA;
					end
				end
				S_B_STO: begin
					if (i_q == '0) begin
						j_q     <= '0;
						state_q <= S_OUT;
					end else begin
						i_q     <= i_q - 1'b1;
						state_q <= S_B_RD;
					end
				end
				S_OUT: begin
					valid <= 1'b1;
					if (j_q == COL_W'(nm1)) begin
						sing_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operand, accumulator, root and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_PIV_CAP: pivot_q <= rd_s;
			S_F_CAP:   b_q     <= rd_s;
			S_E_RDI:   a_q     <= rd_s;
			S_E_MUL:   c_q     <= rd_s;
			S_B_CAP:   c_q     <= rd_s;
			S_B_RDA:   b_q     <= x_rd;
			S_B_CAPA:  a_q     <= rd_s;
			S_B_SUB:   c_q     <= diff;
			S_B_STO:   xs_q[i_q] <= c_q;
			S_OUT: begin
				root       <= x_rd;
				root_index <= 4'(j_q);
				last_root  <= j_q == COL_W'(nm1);
				singular   <= sing_q;
			end
			default: begin
				pivot_q <= pivot_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(state_q == S_OUT))
		else $error("root strobe without output step");
	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last_root) |=> (valid && (root_index == $past(root_index) + 4'd1)))
		else $error("roots not consecutive");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last_root) |=> !valid)
		else $error("root after last root");
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_NRM_WAIT))
		else $error("divider finished outside wait step");
`endif

endmodule

// ===== src/gesu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gesu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/gesu_div.sv =====
// Iterative Q16.16 divider, one quotient bit a cycle, with saturation.
module gesu_div (
	input  logic                clk,
	input  logic                arst_n,
	input  gesu_pkg::div_req_t  req,
	output gesu_pkg::div_rsp_t  rsp
);
	import gesu_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [QUOT_W-1:0] dq_q;
	logic [DATA_W-1:0] den_q;
	logic              neg_q;
	logic              apos_q;
	logic              aneg_q;
	logic              bzero_q;
	logic [DATA_W-1:0] ua;
	logic [DATA_W-1:0] ub;
	logic [DATA_W:0]   trial;
	logic              ge;

	// Magnitudes of the operands.
	assign ua = req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign ub = req.divisor[DATA_W-1] ? (~req.divisor + 1'b1) : req.divisor;

	// One restoring step.
	assign trial = {rem_q, dq_q[QUOT_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath of the iteration.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= '0;
			dq_q    <= {ua, 16'h0000};
			den_q   <= ub;
			neg_q   <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
			apos_q  <= !req.dividend[DATA_W-1] && (req.dividend != '0);
			aneg_q  <= req.dividend[DATA_W-1];
			bzero_q <= req.divisor == '0;
		end else if (busy_q) begin
			rem_q <= ge ? DATA_W'(trial - {1'b0, den_q}) : trial[DATA_W-1:0];
			dq_q  <= {dq_q[QUOT_W-2:0], ge};
		end
	end

	// Sign and saturation of the finished quotient.
	always_comb begin
		rsp.done = done_q;
		if (bzero_q) begin
			rsp.quot = apos_q ? SMAX : (aneg_q ? SMIN : '0);
		end else if (neg_q) begin
			rsp.quot = (dq_q > QUOT_W'(48'h0000_8000_0000)) ? SMIN : DATA_W'(~dq_q + 1'b1);
		end else begin
			rsp.quot = (dq_q > QUOT_W'(48'h0000_7fff_ffff)) ? SMAX : dq_q[DATA_W-1:0];
		end
	end

endmodule

// ===== dv/gaussian_elimination_solver_unit_tb.sv =====
// Self-checking testbench for the Gaussian elimination solver unit.
`timescale 1ns / 1ps

module gaussian_elimination_solver_unit_tb;
	import gesu_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_GOAL   = 380;
	localparam int CALM_AFTER  = 330;
	localparam logic [2:0] EQUATIONS_ADDR = 3'd0;

	typedef enum int {FILL_DOMINANT, FILL_WILD, FILL_INTEGER, FILL_DEGENERATE} fill_t;

	// One expected root.
	typedef struct {
		logic signed [31:0] root;
		logic [3:0]         root_index;
		logic               last_root;
		logic               singular;
	} root_t;

	// Holds the solver's shadow state and the roots still owed by the block.
	class root_scoreboard;
		logic signed [31:0] mat [MAX_EQUATIONS][COLS];
		logic [4:0] equations;
		int unsigned load_pos;
		bit sing;
		root_t owed [$];
		int errors;
		int roots_seen;
		int systems;

		function new();
			equations = 5'd1;
			load_pos  = 0;
			sing      = 0;
			errors    = 0;
			roots_seen = 0;
			systems   = 0;
		endfunction

		function int size_n();
			if (equations == 0) return 1;
			if (equations > MAX_EQUATIONS) return MAX_EQUATIONS;
			return equations;
		endfunction

		function logic signed [31:0] sat(longint v);
			if (v > 64'sd2147483647) return SMAX;
			if (v < -64'sd2147483648) return SMIN;
			return v[31:0];
		endfunction

		function logic signed [31:0] fmul(logic signed [31:0] a, logic signed [31:0] b);
			longint p;
			p = longint'(a) * longint'(b);
			return sat(p / 65536);
		endfunction

		function logic signed [31:0] fdiv(logic signed [31:0] a, logic signed [31:0] b);
			if (b == 0) return (a > 0) ? SMAX : ((a < 0) ? SMIN : 32'sd0);
			return sat((longint'(a) * 65536) / longint'(b));
		endfunction

		function logic signed [31:0] fsub(logic signed [31:0] a, logic signed [31:0] b);
			return sat(longint'(a) - longint'(b));
		endfunction

		// A register write discards any partly loaded system.
		function void configure(logic [4:0] value);
			equations = value;
			load_pos  = 0;
			sing      = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Stores one accepted element; the final one of a system solves it.
		function void note_element(logic signed [31:0] value);
			int n;
			int unsigned pos;
			longint mag;
			logic signed [31:0] pivot, f, acc;
			logic signed [31:0] x [MAX_EQUATIONS];
			root_t r;
			n = size_n();
			pos = load_pos;
			if (pos >= n * (n + 1)) pos = 0;
			mat[pos / (n + 1)][pos % (n + 1)] = value;
			pos++;
			if (pos < n * (n + 1)) begin
				load_pos = pos;
				return;
			end
			// Forward elimination without pivoting.
			for (int k = 0; k < n; k++) begin
				pivot = mat[k][k];
				mag = (pivot < 0) ? -longint'(pivot) : longint'(pivot);
				if (mag < PIVOT_LIMIT) sing = 1;
				for (int j = k; j <= n; j++) mat[k][j] = fdiv(mat[k][j], pivot);
				for (int i = k + 1; i < n; i++) begin
					f = mat[i][k];
					for (int j = k; j <= n; j++)
						mat[i][j] = fsub(mat[i][j], fmul(mat[k][j], f));
				end
			end
			// Back substitution, last unknown first.
			for (int i = n - 1; i >= 0; i--) begin
				acc = mat[i][n];
				for (int j = i + 1; j < n; j++) acc = fsub(acc, fmul(mat[i][j], x[j]));
				x[i] = acc;
			end
			for (int i = 0; i < n; i++) begin
				r.root       = x[i];
				r.root_index = i[3:0];
				r.last_root  = (i == n - 1);
				r.singular   = sing;
				owed.push_back(r);
			end
			systems++;
			load_pos = 0;
			sing = 0;
		endfunction

		// Compares one emitted root with the oldest one owed.
		function void check_root(logic signed [31:0] root, logic [3:0] idx, logic last,
				logic sg);
			root_t e;
			roots_seen++;
			if (owed.size() == 0) begin
				$error("unexpected root %0d (index %0d)", root, idx);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (root !== e.root) begin
				$error("root: expected %0d, actual %0d", e.root, root);
				errors++;
			end
			if (idx !== e.root_index) begin
				$error("root_index: expected %0d, actual %0d", e.root_index, idx);
				errors++;
			end
			if (last !== e.last_root) begin
				$error("last_root: expected %0b, actual %0b", e.last_root, last);
				errors++;
			end
			if (sg !== e.singular) begin
				$error("singular: expected %0b, actual %0b", e.singular, sg);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] element;
	logic               valid;
	logic signed [31:0] root;
	logic [3:0]         root_index;
	logic               last_root;
	logic               singular;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	root_scoreboard sb;
	int cycles;
	int items_sent;

	gaussian_elimination_solver_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .element(element),
		.valid(valid), .root(root), .root_index(root_index), .last_root(last_root),
		.singular(singular), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Result monitor: roots are sampled at the edge that ends their cycle.
	always @(posedge clk) begin
		if (arst_n && valid) sb.check_root(root, root_index, last_root, singular);
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Sends one element and waits until the block takes it; start stays high.
	task automatic send_element(logic signed [31:0] value);
		start   <= 1'b1;
		element <= value;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_element(value);
		items_sent++;
	endtask

	// Random sender idling, none in the closing stretch.
	task automatic sender_gap();
		if (items_sent < CALM_AFTER && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Lets the block drain, then writes the equation count over APB.
	task automatic write_equations(logic [4:0] value);
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= EQUATIONS_ADDR;
		pwdata  <= {$urandom_range(0, 1) ? 27'h7ffffff : 27'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.configure(value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Picks one element of a random system according to its fill style.
	function automatic logic signed [31:0] pick_element(fill_t fill, int r, int c, int n);
		logic signed [31:0] v;
		case (fill)
			FILL_DOMINANT: begin
				if (r == c) begin
					v = 32'(n * 65536 + $urandom_range(0, 4 * 65536));
					if ($urandom_range(0, 1)) v = -v;
				end else begin
					v = 32'($urandom_range(0, 2 * 65536)) - 32'sd65536;
				end
			end
			FILL_WILD: v = $urandom;
			FILL_INTEGER: v = (32'($urandom_range(0, 40)) - 32'sd20) <<< 16;
			default: begin
				v = (r == c && $urandom_range(0, 1)) ? 32'($urandom_range(0, 6))
					: 32'($urandom_range(0, 8 * 65536)) - 32'sd262144;
			end
		endcase
		return v;
	endfunction

	task automatic send_system(fill_t fill);
		int n;
		n = sb.size_n();
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c <= n; c++) begin
				sender_gap();
				send_element(pick_element(fill, r, c, n));
			end
		end
	endtask

	initial begin
		logic [4:0] eq;
		fill_t fill;
		int big_done;
		sb = new();
		cycles = 0;
		items_sent = 0;
		big_done = 0;
		start = 1'b0;
		element = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single equations at reset size: field extremes, zero and tiny pivots.
		send_element(32'sd65536);  send_element(SMAX);
		send_element(SMIN);        send_element(SMIN);
		send_element(32'sd0);      send_element(32'sd5);
		send_element(32'sd0);      send_element(-32'sd5);
		send_element(32'sd0);      send_element(32'sd0);
		send_element(32'sd3);      send_element(-32'sd100);
		send_element(32'sd1);      send_element(32'sd65536);
		send_element(-32'sd65536); send_element(32'sd7);
		// Two equations: identity, then a zero leading pivot.
		write_equations(5'd2);
		send_element(32'sd65536); send_element(32'sd0); send_element(32'sd131072);
		send_element(32'sd0); send_element(32'sd65536); send_element(-32'sd196608);
		send_element(32'sd0); send_element(32'sd65536); send_element(32'sd65536);
		send_element(32'sd65536); send_element(32'sd0); send_element(SMAX);
		// A partial load is dropped by a register write.
		write_equations(5'd16);
		for (int i = 0; i < 5; i++) send_element($urandom);
		write_equations(5'd0);
		send_element(SMAX); send_element(SMIN);

		// Random systems over a range of sizes, one at the largest size.
		while (items_sent < ITEM_GOAL) begin
			if (!big_done && items_sent > 60) begin
				eq = 5'd31;
				big_done = 1;
			end else begin
				eq = 5'($urandom_range(0, 6));
			end
			write_equations(eq);
			repeat ((eq > 6) ? 1 : $urandom_range(1, 4)) begin
				if (items_sent < ITEM_GOAL) begin
					case ($urandom_range(0, 9))
						0, 1:    fill = FILL_WILD;
						2, 3:    fill = FILL_INTEGER;
						4:       fill = FILL_DEGENERATE;
						default: fill = FILL_DOMINANT;
					endcase
					send_system(fill);
				end
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d elements forming %0d systems, checked %0d roots.",
			items_sent, sb.systems, sb.roots_seen);
		$display("Sizes from one to sixteen equations, with singular and saturating cases.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
